### sv/assert_macros.svh
// ------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the deframer checkers.
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define BBD_ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("assertion failed");

// next-cycle implication, disabled during reset
`define BBD_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("assertion failed");

// next-cycle implication, active during reset as well
`define BBD_ASSERT_NEXT_ALWAYS(label, clk, a, b) \
    label: assert property (@(posedge clk) (a) |=> (b)) \
        else $error("assertion failed");

`endif

### sv/bbd_pkg.sv
// ------------------------------------------------------------------------
// bbd_pkg
// Types, constants and the CRC-8 step for the baseband TS packet deframer.
// ------------------------------------------------------------------------
package bbd_pkg;

    localparam int unsigned PACKET_BYTES_DEF = 188;
    localparam int unsigned RESULT_DEPTH_DEF = 4;

    localparam int unsigned DATA_W  = 8;
    localparam int unsigned POS_W   = 13;
    localparam int unsigned START_W = 14;

    localparam logic [POS_W-1:0] POS_MAX  = 13'h1FFF;
    localparam logic [7:0]       CRC_POLY = 8'hD5;

    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [DATA_W-1:0] out_byte;
        logic              packet_good;
        logic              last;
    } t_result;

    // results of one accepted transaction, count is 0, 1 or 2
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_push;

    typedef struct packed {
        logic not_empty;
        logic has_room;
    } t_queue_status;

    // one byte of CRC-8, MSB first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

### sv/bbd_in_if.sv
// ------------------------------------------------------------------------
// bbd_in_if
// Input channel: one data-field byte with the frame header fields.
// ------------------------------------------------------------------------
interface bbd_in_if import bbd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [DATA_W-1:0]  data_byte;
    logic               frame_start;
    logic               header_good;
    logic [POS_W-1:0]   sync_offset_bytes;
    logic [POS_W-1:0]   field_length_bytes;
    logic [DATA_W-1:0]  sync_value;

    modport source (
        output valid, data_byte, frame_start, header_good,
               sync_offset_bytes, field_length_bytes, sync_value,
        input  ready
    );
    modport sink (
        input  valid, data_byte, frame_start, header_good,
               sync_offset_bytes, field_length_bytes, sync_value,
        output ready
    );
endinterface

### sv/bbd_out_if.sv
// ------------------------------------------------------------------------
// bbd_out_if
// Output channel: packet byte or end-of-packet status.
// ------------------------------------------------------------------------
interface bbd_out_if import bbd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               kind;
    logic [DATA_W-1:0]  out_byte;
    logic               packet_good;
    logic               last;

    modport source (
        output valid, kind, out_byte, packet_good, last,
        input  ready
    );
    modport sink (
        input  valid, kind, out_byte, packet_good, last,
        output ready
    );
endinterface

### sv/bbd_core.sv
// ------------------------------------------------------------------------
// bbd_core
// Frame/packet state, CRC-8 update and result generation per byte.
// ------------------------------------------------------------------------
module bbd_core import bbd_pkg::*; #(
    parameter int unsigned PACKET_BYTES = PACKET_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [DATA_W-1:0]  i_data_byte,
    input  logic               i_frame_start,
    input  logic               i_header_good,
    input  logic [POS_W-1:0]   i_sync_offset_bytes,
    input  logic [POS_W-1:0]   i_field_length_bytes,
    input  logic [DATA_W-1:0]  i_sync_value,
    output t_push              o_push
);

    localparam int unsigned FILL_W = $clog2(PACKET_BYTES + 1);
    localparam logic [FILL_W-1:0] FILL_END = FILL_W'(PACKET_BYTES);

    logic [POS_W-1:0]   r_pos,      n_pos;
    logic               r_hdr_good, n_hdr_good;
    logic [START_W-1:0] r_start,    n_start;
    logic [POS_W-1:0]   r_len,      n_len;
    logic [FILL_W-1:0]  r_fill,     n_fill;
    logic [7:0]         r_crc,      n_crc;
    logic [DATA_W-1:0]  r_sync,     n_sync;

    logic [POS_W-1:0]   pos_cur;
    logic [FILL_W-1:0]  fill_inc;
    logic [7:0]         crc_new;
    logic               in_field;
    logic               do_feed;
    logic               resync;
    logic               pkt_done;
    t_result            res_sync;
    t_result            res_tail;

    always_comb begin
        n_hdr_good = i_frame_start ? i_header_good : r_hdr_good;
        n_start    = i_frame_start ? ({1'b0, i_sync_offset_bytes} + START_W'(1)) : r_start;
        n_len      = i_frame_start ? i_field_length_bytes : r_len;
        n_sync     = (i_frame_start && i_header_good) ? i_sync_value : r_sync;
        pos_cur    = i_frame_start ? '0 : r_pos;

        in_field = pos_cur < n_len;
        do_feed  = !n_hdr_good || in_field;
        resync   = n_hdr_good && in_field && (({1'b0, pos_cur} + START_W'(1)) == n_start);

        crc_new  = crc8_byte(r_crc, i_data_byte);
        fill_inc = r_fill + FILL_W'(1);
        pkt_done = fill_inc >= FILL_END;

        n_fill = r_fill;
        n_crc  = r_crc;
        if (do_feed) begin
            if (pkt_done) begin
                n_fill = '0;
                n_crc  = '0;
            end else begin
                n_fill = fill_inc;
                n_crc  = crc_new;
            end
        end
        // restart the unit after the sync offset byte
        if (resync) begin
            n_fill = '0;
            n_crc  = '0;
        end

        n_pos = (pos_cur < POS_MAX) ? (pos_cur + POS_W'(1)) : pos_cur;

        res_sync.kind        = KIND_BYTE;
        res_sync.out_byte    = n_sync;
        res_sync.packet_good = 1'b0;
        res_sync.last        = 1'b0;

        res_tail.kind        = pkt_done ? KIND_STATUS : KIND_BYTE;
        res_tail.out_byte    = pkt_done ? '0 : i_data_byte;
        res_tail.packet_good = pkt_done && (crc_new == 8'h00);
        res_tail.last        = 1'b1;

        o_push = '0;
        if (i_accept && do_feed) begin
            if (r_fill == '0) begin
                o_push.count = 2'd2;
                o_push.res0  = res_sync;
                o_push.res1  = res_tail;
            end else begin
                o_push.count = 2'd1;
                o_push.res0  = res_tail;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_hdr_good <= 1'b0;
            r_start    <= '0;
            r_len      <= '0;
            r_fill     <= '0;
            r_crc      <= '0;
            r_sync     <= '0;
        end else if (i_accept) begin
            r_pos      <= n_pos;
            r_hdr_good <= n_hdr_good;
            r_start    <= n_start;
            r_len      <= n_len;
            r_fill     <= n_fill;
            r_crc      <= n_crc;
            r_sync     <= n_sync;
        end
    end

endmodule

### sv/bbd_queue.sv
// ------------------------------------------------------------------------
// bbd_queue
// Result queue: takes up to two results per cycle, hands out one.
// ------------------------------------------------------------------------
module bbd_queue import bbd_pkg::*; #(
    parameter int unsigned DEPTH = RESULT_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_push         i_push,
    input  logic          i_pop,
    output t_result       o_head,
    output t_queue_status o_status
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] ROOM_MAX = CNT_W'(DEPTH - 2);

    t_result           r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr, n_wr;
    logic [PTR_W-1:0]  r_rd, n_rd;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [PTR_W-1:0]  wr1;
    logic [PTR_W-1:0]  wr2;

    always_comb begin
        wr1 = (r_wr == PTR_LAST) ? '0 : r_wr + PTR_W'(1);
        wr2 = (wr1 == PTR_LAST) ? '0 : wr1 + PTR_W'(1);
        case (i_push.count)
            2'd1:    n_wr = wr1;
            2'd2:    n_wr = wr2;
            default: n_wr = r_wr;
        endcase
        if (i_pop) begin
            n_rd = (r_rd == PTR_LAST) ? '0 : r_rd + PTR_W'(1);
        end else begin
            n_rd = r_rd;
        end
        n_count = r_count + CNT_W'(i_push.count) - CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.res0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr1] <= i_push.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    assign o_head             = r_mem[r_rd];
    assign o_status.not_empty = r_count != '0;
    // keep room for a two-result transaction
    assign o_status.has_room  = r_count <= ROOM_MAX;

endmodule

### sv/bbframe_ts_packet_deframer.sv
// ------------------------------------------------------------------------
// bbframe_ts_packet_deframer: the results of each input transaction are written into the
// registered result queue. Throughput 1 byte per cycle while the queue holds at most two results;
// a unit of PACKET_BYTES bytes yields one result more, so even a ready output stalls
// the input at times (output port sets the long-run rate).
// Reset: synchronous, clears frame/packet state and empties the result queue.
// ------------------------------------------------------------------------
module bbframe_ts_packet_deframer import bbd_pkg::*; #(
    parameter int unsigned PACKET_BYTES = PACKET_BYTES_DEF,
    parameter int unsigned RESULT_DEPTH = RESULT_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bbd_in_if.sink     i_in,
    bbd_out_if.source  o_out
);

    t_push         push;
    t_result       head;
    t_queue_status q_status;
    logic          in_accept;
    logic          out_pop;

    assign in_accept  = i_in.valid && i_in.ready;
    assign out_pop    = o_out.valid && o_out.ready;
    assign i_in.ready = q_status.has_room;

    bbd_core #(
        .PACKET_BYTES (PACKET_BYTES)
    ) u_core (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_accept             (in_accept),
        .i_data_byte          (i_in.data_byte),
        .i_frame_start        (i_in.frame_start),
        .i_header_good        (i_in.header_good),
        .i_sync_offset_bytes  (i_in.sync_offset_bytes),
        .i_field_length_bytes (i_in.field_length_bytes),
        .i_sync_value         (i_in.sync_value),
        .o_push               (push)
    );

    bbd_queue #(
        .DEPTH (RESULT_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_pop    (out_pop),
        .o_head   (head),
        .o_status (q_status)
    );

    assign o_out.valid       = q_status.not_empty;
    assign o_out.kind        = head.kind;
    assign o_out.out_byte    = head.out_byte;
    assign o_out.packet_good = head.packet_good;
    assign o_out.last        = head.last;

endmodule

### sv/bbd_checker.sv
// ------------------------------------------------------------------------
// bbd_checker
// Port-level assertions for the deframer, bound to the top level.
// ------------------------------------------------------------------------
`include "assert_macros.svh"

module bbd_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_kind,
    input logic i_out_last
);

    // hold a stalled result
    `BBD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    // empty result queue always has room for a transaction
    `BBD_ASSERT_IMPLY(a_empty_ready, i_clk, i_rst_n, !i_out_valid, i_in_ready)
    // a status result closes the results of its transaction
    `BBD_ASSERT_IMPLY(a_status_last, i_clk, i_rst_n, i_out_valid && i_out_kind, i_out_last)
    // reset leaves the block ready and the output empty
    `BBD_ASSERT_NEXT_ALWAYS(a_reset_ready, i_clk, !i_rst_n, i_in_ready && !i_out_valid)

endmodule

bind bbframe_ts_packet_deframer bbd_checker u_bbd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_kind  (o_out.kind),
    .i_out_last  (o_out.last)
);

### bench/bbframe_ts_packet_deframer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbframe_ts_packet_deframer_tb
// Drives data-field bytes of baseband frames into the deframer and checks
// every packet byte and end-of-packet status against a cycle-free predictor.
// The stimulus is a directed set of header corner cases, random frames cut
// from a CRC-framed packet stream with bad-header and noise frames mixed in,
// and one closing frame with no idles. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module bbframe_ts_packet_deframer_tb;
    import bbd_pkg::*;

    localparam int unsigned PKT_LEN      = PACKET_BYTES_DEF;
    localparam int          RANDOM_ITEMS = 400;

    typedef enum logic [1:0] {
        PH_TX_LIGHT,
        PH_TX_HEAVY,
        PH_NO_IDLE
    } t_idle_phase;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        frame_start;
        logic        header_good;
        logic [12:0] sync_offset_bytes;
        logic [12:0] field_length_bytes;
        logic [7:0]  sync_value;
        t_idle_phase phase;
    } t_byte_item;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    bbd_in_if  in_ch ();
    bbd_out_if out_ch ();

    bbframe_ts_packet_deframer DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #5 i_clk = ~i_clk;

    t_byte_item  frame_bytes [$];
    t_result     deframed_expected [$];
    int          n_driven = 0;
    int          n_accepted = 0;
    int          n_mismatch = 0;
    t_idle_phase rx_phase = PH_TX_LIGHT;

    // deframer state as seen by the predictor
    logic [12:0] m_frame_pos = '0;
    logic        m_hdr_good = 1'b0;
    logic [13:0] m_start = '0;
    logic [12:0] m_length = '0;
    logic [7:0]  m_fill = '0;
    logic [7:0]  m_crc = '0;
    logic [7:0]  m_sync = '0;

    // packet stream generator state
    int          ts_unit_pos = 0;
    logic [7:0]  ts_crc = '0;

    // bit-serial CRC-8, poly 0xD5, MSB first
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        logic       fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[7] ^ b[i];
            c  = {c[6:0], 1'b0} ^ (fb ? 8'hD5 : 8'h00);
        end
        return c;
    endfunction

    task automatic deframe_byte(input t_byte_item it);
        t_result     r [0:1];
        int          n;
        logic [12:0] p;
        n = 0;
        if (it.frame_start) begin
            m_frame_pos = '0;
            m_hdr_good  = it.header_good;
            m_start     = {1'b0, it.sync_offset_bytes} + 14'd1;
            m_length    = it.field_length_bytes;
            if (it.header_good) begin
                m_sync = it.sync_value;
            end
        end
        p = m_frame_pos;
        if (!m_hdr_good || p < m_length) begin
            if (m_fill == 8'd0) begin
                r[n] = '{kind: KIND_BYTE, out_byte: m_sync, packet_good: 1'b0, last: 1'b0};
                n++;
            end
            m_crc  = crc8_step(m_crc, it.data_byte);
            m_fill = m_fill + 8'd1;
            if (m_fill >= PKT_LEN) begin
                r[n] = '{kind: KIND_STATUS, out_byte: 8'h00, packet_good: (m_crc == 8'h00),
                         last: 1'b0};
                m_fill = '0;
                m_crc  = '0;
            end else begin
                r[n] = '{kind: KIND_BYTE, out_byte: it.data_byte, packet_good: 1'b0,
                         last: 1'b0};
            end
            n++;
            // resync: the byte at the sync offset closes the packet in progress
            if (m_hdr_good && ({1'b0, p} + 14'd1 == m_start)) begin
                m_fill = '0;
                m_crc  = '0;
            end
        end
        if (m_frame_pos != POS_MAX) begin
            m_frame_pos = m_frame_pos + 13'd1;
        end
        if (n > 0) begin
            r[n-1].last = 1'b1;
        end
        for (int i = 0; i < n; i++) begin
            deframed_expected.push_back(r[i]);
        end
    endtask

    // next byte of a stream of 187 data bytes + CRC byte units
    function automatic logic [7:0] next_ts_byte();
        logic [7:0] b;
        if (ts_unit_pos < PKT_LEN - 1) begin
            b = 8'($urandom);
            ts_crc = crc8_step(ts_crc, b);
            ts_unit_pos++;
        end else begin
            b = ts_crc;
            if ($urandom_range(0, 99) < 15) begin
                b = b ^ 8'($urandom_range(1, 255));
            end
            ts_crc = '0;
            ts_unit_pos = 0;
        end
        return b;
    endfunction

    task automatic push_item(input logic [7:0] data, input logic fs, input logic hg,
                             input logic [12:0] syncd, input logic [12:0] dfl,
                             input logic [7:0] sv, input t_idle_phase ph);
        frame_bytes.push_back('{data_byte: data, frame_start: fs, header_good: hg,
                                sync_offset_bytes: syncd, field_length_bytes: dfl,
                                sync_value: sv, phase: ph});
    endtask

    // byte inside a frame: header fields carry junk and must be ignored
    task automatic push_body(input logic [7:0] data, input t_idle_phase ph);
        push_item(data, 1'b0, 1'($urandom), 13'($urandom), 13'($urandom), 8'($urandom), ph);
    endtask

    task automatic add_stream_frame(input logic hg, input int n_stream, input int n_pad,
                                    input t_idle_phase ph);
        logic [7:0]  fb [$];
        int          sync_at;
        logic [12:0] syncd;
        logic [12:0] dfl;
        logic [7:0]  sv;
        sync_at = -1;
        for (int i = 0; i < n_stream; i++) begin
            if (sync_at < 0 && ts_unit_pos == PKT_LEN - 1) begin
                sync_at = i;
            end
            fb.push_back(next_ts_byte());
        end
        if (hg) begin
            dfl   = 13'(n_stream);
            syncd = (sync_at >= 0) ? 13'(sync_at) : 13'($urandom_range(n_stream, 8191));
            sv    = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h47;
        end else begin
            dfl   = 13'($urandom);
            syncd = 13'($urandom);
            sv    = 8'($urandom);
        end
        push_item(fb[0], 1'b1, hg, syncd, dfl, sv, ph);
        for (int i = 1; i < fb.size(); i++) begin
            push_body(fb[i], ph);
        end
        repeat (n_pad) push_body(8'($urandom), ph);
    endtask

    function automatic bit tx_idle(input t_idle_phase ph);
        case (ph)
            PH_TX_LIGHT: return $urandom_range(0, 99) < 6;
            PH_TX_HEAVY: return $urandom_range(0, 99) < 53;
            default:     return 1'b0;
        endcase
    endfunction

    function automatic bit rx_idle(input t_idle_phase ph);
        case (ph)
            PH_TX_LIGHT: return $urandom_range(0, 99) < 53;
            PH_TX_HEAVY: return $urandom_range(0, 99) < 6;
            default:     return 1'b0;
        endcase
    endfunction

    // driver: present the head of the queue, hold it until the transaction
    always @(negedge i_clk) begin
        if (i_rst_n && (!in_ch.valid || n_accepted == n_driven)) begin
            if (frame_bytes.size() == 0 || tx_idle(frame_bytes[0].phase)) begin
                in_ch.valid <= 1'b0;
            end else begin
                in_ch.valid              <= 1'b1;
                in_ch.data_byte          <= frame_bytes[0].data_byte;
                in_ch.frame_start        <= frame_bytes[0].frame_start;
                in_ch.header_good        <= frame_bytes[0].header_good;
                in_ch.sync_offset_bytes  <= frame_bytes[0].sync_offset_bytes;
                in_ch.field_length_bytes <= frame_bytes[0].field_length_bytes;
                in_ch.sync_value         <= frame_bytes[0].sync_value;
                n_driven                 <= n_driven + 1;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= !rx_idle(rx_phase);
        end
    end

    // predict from what the block actually took
    always @(posedge i_clk) begin : accept_in
        t_byte_item it;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            it = '{data_byte: in_ch.data_byte, frame_start: in_ch.frame_start,
                   header_good: in_ch.header_good,
                   sync_offset_bytes: in_ch.sync_offset_bytes,
                   field_length_bytes: in_ch.field_length_bytes,
                   sync_value: in_ch.sync_value, phase: frame_bytes[0].phase};
            rx_phase <= it.phase;
            deframe_byte(it);
            void'(frame_bytes.pop_front());
            n_accepted <= n_accepted + 1;
        end
    end

    always @(posedge i_clk) begin : check_out
        t_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (deframed_expected.size() == 0) begin
                if (n_mismatch < 10) begin
                    $display("unexpected result: kind %0d byte %02h good %0d last %0d",
                             out_ch.kind, out_ch.out_byte, out_ch.packet_good, out_ch.last);
                end
                n_mismatch++;
            end else begin
                want = deframed_expected.pop_front();
                if (out_ch.kind !== want.kind || out_ch.out_byte !== want.out_byte ||
                    out_ch.packet_good !== want.packet_good || out_ch.last !== want.last) begin
                    if (n_mismatch < 10) begin
                        $display({"mismatch (expected/actual): kind %0d/%0d byte %02h/%02h",
                                  " good %0d/%0d last %0d/%0d"},
                                 want.kind, out_ch.kind, want.out_byte, out_ch.out_byte,
                                 want.packet_good, out_ch.packet_good, want.last, out_ch.last);
                    end
                    n_mismatch++;
                end
            end
        end
    end

    initial begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int          n_directed;
        int          n_total;
        int          n_len;
        t_idle_phase ph;
        in_ch.valid              = 1'b0;
        in_ch.data_byte          = '0;
        in_ch.frame_start        = 1'b0;
        in_ch.header_good        = 1'b0;
        in_ch.sync_offset_bytes  = '0;
        in_ch.field_length_bytes = '0;
        in_ch.sync_value         = '0;
        out_ch.ready             = 1'b0;

        // bytes before any frame: header counts as bad, all fed
        push_body(8'h00, PH_TX_LIGHT);
        push_body(8'hFF, PH_TX_LIGHT);
        // sync offset zero, one ignored byte past the data field
        push_item(8'hFF, 1'b1, 1'b1, 13'd0, 13'd4, 8'hFF, PH_TX_LIGHT);
        push_body(8'h00, PH_TX_LIGHT);
        push_body(8'h5A, PH_TX_LIGHT);
        push_body(8'hA5, PH_TX_LIGHT);
        push_body(8'hFF, PH_TX_LIGHT);
        // empty data field: everything ignored, no result
        push_item(8'h12, 1'b1, 1'b1, 13'h1FFF, 13'd0, 8'h00, PH_TX_LIGHT);
        push_body(8'h34, PH_TX_LIGHT);
        // start beyond the data field, widest fields
        push_item(8'h80, 1'b1, 1'b1, 13'h1FFF, 13'h1FFF, 8'h00, PH_TX_LIGHT);
        push_body(8'h01, PH_TX_LIGHT);
        push_body(8'hFE, PH_TX_LIGHT);
        push_body(8'h7F, PH_TX_LIGHT);
        // bad header: sync byte not latched, all bytes fed
        push_item(8'h11, 1'b1, 1'b0, 13'd0, 13'd0, 8'hAB, PH_TX_LIGHT);
        push_body(8'h22, PH_TX_LIGHT);
        push_body(8'h33, PH_TX_LIGHT);
        // resync on the last byte of the data field
        push_item(8'hC3, 1'b1, 1'b1, 13'd2, 13'd3, 8'h47, PH_TX_LIGHT);
        push_body(8'h3C, PH_TX_LIGHT);
        push_body(8'h96, PH_TX_LIGHT);
        push_body(8'h69, PH_TX_LIGHT);
        n_directed = frame_bytes.size();

        while (frame_bytes.size() - n_directed < RANDOM_ITEMS) begin
            ph = t_idle_phase'((frame_bytes.size() - n_directed) * 3 / RANDOM_ITEMS);
            case ($urandom_range(0, 99)) inside
                [0:64]: begin
                    n_len = ($urandom_range(0, 9) < 6) ? $urandom_range(8, 60)
                                                        : $urandom_range(61, 300);
                    add_stream_frame(1'b1, n_len, $urandom_range(0, 3), ph);
                end
                [65:79]: add_stream_frame(1'b0, $urandom_range(4, 80), 0, ph);
                default: begin
                    // noise frame: random header, random bytes, breaks alignment
                    push_item(8'($urandom), 1'b1, ($urandom_range(0, 3) != 0),
                              $urandom_range(0, 1) ? 13'($urandom_range(0, 40))
                                                   : 13'($urandom),
                              $urandom_range(0, 1) ? 13'($urandom_range(0, 60))
                                                   : 13'($urandom),
                              8'($urandom), ph);
                    repeat ($urandom_range(0, 40)) push_body(8'($urandom), ph);
                end
            endcase
        end

        // closing frame with padding past the data field, no idles
        add_stream_frame(1'b1, 40, 9, PH_NO_IDLE);
        n_total = frame_bytes.size();

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted != n_total) @(posedge i_clk);
        while (deframed_expected.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (n_mismatch == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
